// File: rtl/gprn_pkg.sv
// Shared types and constants for the gamepad report normaliser.
// Used by gprn_store, gprn_cond and gamepad_report_normalizer_unit; no dependencies.
package gprn_pkg;

    localparam int SLOT_W  = 3;
    localparam int TDATA_IN_W  = 104;
    localparam int TDATA_OUT_W = 88;

    localparam logic [7:0] REPORT_ID_GAMEPAD = 8'd1;
    localparam logic [7:0] STICK_CENTRE      = 8'd128;

    // APB register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEADZONE    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_DELTA_LIMIT = 2'd2;

    localparam logic [7:0] DEADZONE_RST    = 8'd40;
    localparam logic [7:0] THRESHOLD_RST   = 8'd2;
    localparam logic [6:0] DELTA_LIMIT_RST = 7'd12;

    // hat codes, clockwise from up; 8..15 neutral
    localparam logic [3:0] HAT_N  = 4'd0;
    localparam logic [3:0] HAT_NE = 4'd1;
    localparam logic [3:0] HAT_E  = 4'd2;
    localparam logic [3:0] HAT_SE = 4'd3;
    localparam logic [3:0] HAT_S  = 4'd4;
    localparam logic [3:0] HAT_SW = 4'd5;
    localparam logic [3:0] HAT_W  = 4'd6;
    localparam logic [3:0] HAT_NW = 4'd7;

    typedef struct packed {
        logic [7:0]  rpt_id;
        logic [2:0]  device_slot;
        logic [7:0]  interface_instance;
        logic [7:0]  stick_lx;
        logic [7:0]  stick_ly;
        logic [7:0]  stick_rx;
        logic [7:0]  stick_ry;
        logic [17:0] buttons_raw;
        logic [7:0]  trigger_l;
        logic [7:0]  trigger_r;
        logic        finger_lifted;
        logic [23:0] touch_pos;
    } report_t;

    // last kept report of one slot
    typedef struct packed {
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  tl;
        logic [7:0]  tr;
        logic [17:0] buttons;
        logic [23:0] touch;
    } prev_t;

    typedef struct packed {
        logic [7:0] deadzone_width;
        logic [7:0] change_threshold;
        logic [6:0] delta_limit;
    } cfg_t;

    typedef struct packed {
        logic [11:0] last_x;
        logic        dragging;
    } touch_t;

    typedef struct packed {
        logic [2:0]  out_slot;
        logic [7:0]  out_instance;
        logic [17:0] buttons;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
        logic [7:0]  touch_delta_x;
    } result_t;

endpackage

// File: rtl/gprn_store.sv
// Previous-report store: one entry per device slot, registered read port,
// write-to-read forwarding and per-entry valid bits. Depends on gprn_pkg.
module gprn_store #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  gprn_pkg::prev_t      wr_data,
    output gprn_pkg::prev_t      rd_data
);

    gprn_pkg::prev_t mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    gprn_pkg::prev_t rd_mem_reg;
    gprn_pkg::prev_t fwd_reg;
    logic            rd_vld_reg;
    logic            rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_mem_reg <= mem[rd_addr];
            fwd_reg    <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
                rd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // never-written entry reads as zero
    assign rd_data = rd_hit_reg ? fwd_reg : (rd_vld_reg ? rd_mem_reg : '0);

endmodule

// File: rtl/gprn_cond.sv
// Per-report logic: change detection, hat decode and button remap, stick
// conditioning and touch delta. Combinational. Depends on gprn_pkg.
module gprn_cond (
    input  gprn_pkg::report_t rep,
    input  gprn_pkg::prev_t   prev,
    input  gprn_pkg::cfg_t    cfg,
    input  gprn_pkg::touch_t  touch,
    output logic              changed,
    output gprn_pkg::result_t res,
    output gprn_pkg::touch_t  touch_next
);

    function automatic logic moved(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] thr);
        logic [7:0] d;
        begin
            d = (a >= b) ? (a - b) : (b - a);
            return d > thr;
        end
    endfunction

    function automatic logic [7:0] cond_stick(input logic [7:0] v, input logic [7:0] w);
        logic [8:0] half;
        logic [7:0] v1;
        logic [8:0] v9;
        begin
            half = {2'b00, w[7:1]};
            v1   = (v == 8'd0) ? 8'd1 : v;
            v9   = {1'b0, v1};
            if ((v9 + half > 9'd128) && (v9 < 9'd128 + half)) begin
                return gprn_pkg::STICK_CENTRE;
            end
            return v1;
        end
    endfunction

    logic [3:0]         hat;
    logic               up, down, left, right;
    logic [11:0]        tx;
    logic signed [12:0] diff;
    logic signed [12:0] lim;
    logic signed [12:0] clamped;

    always_comb begin
        changed = moved(rep.stick_lx, prev.lx, cfg.change_threshold)
               || moved(rep.stick_ly, prev.ly, cfg.change_threshold)
               || moved(rep.stick_rx, prev.rx, cfg.change_threshold)
               || moved(rep.stick_ry, prev.ry, cfg.change_threshold)
               || moved(rep.trigger_l, prev.tl, cfg.change_threshold)
               || moved(rep.trigger_r, prev.tr, cfg.change_threshold)
               || (rep.buttons_raw != prev.buttons)
               || (rep.touch_pos != prev.touch);
    end

    always_comb begin
        hat   = rep.buttons_raw[3:0];
        up    = hat inside {gprn_pkg::HAT_NW, gprn_pkg::HAT_N, gprn_pkg::HAT_NE};
        down  = hat inside {gprn_pkg::HAT_SE, gprn_pkg::HAT_S, gprn_pkg::HAT_SW};
        left  = hat inside {gprn_pkg::HAT_SW, gprn_pkg::HAT_W, gprn_pkg::HAT_NW};
        right = hat inside {gprn_pkg::HAT_NE, gprn_pkg::HAT_E, gprn_pkg::HAT_SE};
    end

    // touch delta, clamped to +/- delta_limit
    always_comb begin
        tx   = rep.touch_pos[11:0];
        diff = $signed({1'b0, tx}) - $signed({1'b0, touch.last_x});
        lim  = $signed({6'b0, cfg.delta_limit});
        if (diff > lim) begin
            clamped = lim;
        end else if (diff < -lim) begin
            clamped = -lim;
        end else begin
            clamped = diff;
        end
        if (!rep.finger_lifted) begin
            touch_next.last_x   = tx;
            touch_next.dragging = 1'b1;
        end else begin
            touch_next.last_x   = touch.last_x;
            touch_next.dragging = 1'b0;
        end
    end

    always_comb begin
        res.out_slot      = rep.device_slot;
        res.out_instance  = rep.interface_instance;
        // triangle, square, circle, cross come from bits 7,4,6,5
        res.buttons       = {rep.buttons_raw[17:8], rep.buttons_raw[7], rep.buttons_raw[4],
                             rep.buttons_raw[6], rep.buttons_raw[5], right, left, down, up};
        res.left_x        = cond_stick(rep.stick_lx, cfg.deadzone_width);
        res.left_y        = cond_stick(~rep.stick_ly, cfg.deadzone_width);
        res.right_x       = cond_stick(rep.stick_rx, cfg.deadzone_width);
        res.right_y       = cond_stick(~rep.stick_ry, cfg.deadzone_width);
        res.left_trigger  = rep.trigger_l;
        res.right_trigger = rep.trigger_r;
        res.touch_delta_x = (!rep.finger_lifted && touch.dragging) ? clamped[7:0] : 8'd0;
    end

endmodule

// File: rtl/gamepad_report_normalizer_unit.sv
// Gamepad report normaliser, top level. Depends on gprn_pkg, gprn_store, gprn_cond.
// Requests pass the input register, then the result register; throughput is one
// request per cycle unless results stall; the slot store read is issued at accept
// and forwarded from the write of the request ahead, so same-slot requests stream.
// Reset (aresetn low, synchronous): stages empty, store valid bits and touch tracking
// cleared, registers back to deadzone 40, threshold 2, delta limit 12. No clearing pass.
module gamepad_report_normalizer_unit #(
    parameter int DEVICE_SLOTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input request
    input  logic         s_tvalid,
    output logic         s_tready,
    // from bit 0: device_slot[3], interface_instance[8], stick_lx[8], stick_ly[8],
    // stick_rx[8], stick_ry[8], buttons_raw[18], trigger_l[8], trigger_r[8],
    // finger_lifted[1], touch_pos[24], zero pad[2]
    input  logic [gprn_pkg::TDATA_IN_W-1:0] s_tdata,
    // rpt_id[8]
    input  logic [7:0]   s_tuser,
    // result
    output logic         m_tvalid,
    input  logic         m_tready,
    // from bit 0: out_slot[3], out_instance[8], buttons[18], left_x[8], left_y[8],
    // right_x[8], right_y[8], left_trigger[8], right_trigger[8], touch_delta_x[8],
    // zero pad[3]
    output logic [gprn_pkg::TDATA_OUT_W-1:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int ADDR_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
    localparam int EXT_W  = ADDR_W + gprn_pkg::SLOT_W;

    // ---------------- configuration registers ----------------
    gprn_pkg::cfg_t cfg_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deadzone_width   <= gprn_pkg::DEADZONE_RST;
            cfg_reg.change_threshold <= gprn_pkg::THRESHOLD_RST;
            cfg_reg.delta_limit      <= gprn_pkg::DELTA_LIMIT_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                gprn_pkg::REG_DEADZONE:    cfg_reg.deadzone_width   <= pwdata[7:0];
                gprn_pkg::REG_THRESHOLD:   cfg_reg.change_threshold <= pwdata[7:0];
                gprn_pkg::REG_DELTA_LIMIT: cfg_reg.delta_limit      <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gprn_pkg::REG_DEADZONE:    prdata = {24'd0, cfg_reg.deadzone_width};
            gprn_pkg::REG_THRESHOLD:   prdata = {24'd0, cfg_reg.change_threshold};
            gprn_pkg::REG_DELTA_LIMIT: prdata = {25'd0, cfg_reg.delta_limit};
            default:                   prdata = 32'd0;
        endcase
    end

    // ---------------- input stage ----------------
    gprn_pkg::report_t s_rep;
    gprn_pkg::report_t a_rep_reg;
    logic              a_vld_reg;
    logic              s_fire;

    always_comb begin
        s_rep.rpt_id             = s_tuser;
        s_rep.device_slot        = s_tdata[2:0];
        s_rep.interface_instance = s_tdata[10:3];
        s_rep.stick_lx           = s_tdata[18:11];
        s_rep.stick_ly           = s_tdata[26:19];
        s_rep.stick_rx           = s_tdata[34:27];
        s_rep.stick_ry           = s_tdata[42:35];
        s_rep.buttons_raw        = s_tdata[60:43];
        s_rep.trigger_l          = s_tdata[68:61];
        s_rep.trigger_r          = s_tdata[76:69];
        s_rep.finger_lifted      = s_tdata[77];
        s_rep.touch_pos          = s_tdata[101:78];
    end

    // ---------------- processing ----------------
    gprn_pkg::prev_t   prev;
    gprn_pkg::prev_t   wr_prev;
    gprn_pkg::result_t res;
    gprn_pkg::touch_t  touch_reg;
    gprn_pkg::touch_t  touch_next;
    logic              changed;
    logic              a_in_range;
    logic              a_emit;
    logic              a_fire;
    logic              out_free;
    logic [EXT_W-1:0]  s_addr_ext;
    logic [EXT_W-1:0]  a_addr_ext;

    assign s_addr_ext = EXT_W'(s_rep.device_slot);
    assign a_addr_ext = EXT_W'(a_rep_reg.device_slot);

    // slots at or above the store depth are dropped
    assign a_in_range = (32'(a_rep_reg.device_slot) < DEVICE_SLOTS);
    assign a_emit     = a_vld_reg && (a_rep_reg.rpt_id == gprn_pkg::REPORT_ID_GAMEPAD)
                        && a_in_range && changed;

    // dropped requests leave without needing result space
    assign out_free = !m_tvalid || m_tready;
    assign a_fire   = a_vld_reg && (!a_emit || out_free);
    assign s_tready = !a_vld_reg || a_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        wr_prev.lx      = a_rep_reg.stick_lx;
        wr_prev.ly      = a_rep_reg.stick_ly;
        wr_prev.rx      = a_rep_reg.stick_rx;
        wr_prev.ry      = a_rep_reg.stick_ry;
        wr_prev.tl      = a_rep_reg.trigger_l;
        wr_prev.tr      = a_rep_reg.trigger_r;
        wr_prev.buttons = a_rep_reg.buttons_raw;
        wr_prev.touch   = a_rep_reg.touch_pos;
    end

    gprn_store #(
        .DEPTH  (DEVICE_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (s_addr_ext[ADDR_W-1:0]),
        .wr_en   (a_emit && a_fire),
        .wr_addr (a_addr_ext[ADDR_W-1:0]),
        .wr_data (wr_prev),
        .rd_data (prev)
    );

    gprn_cond u_cond (
        .rep        (a_rep_reg),
        .prev       (prev),
        .cfg        (cfg_reg),
        .touch      (touch_reg),
        .changed    (changed),
        .res        (res),
        .touch_next (touch_next)
    );

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_rep_reg <= s_rep;
        end
    end

    // ---------------- result register and control ----------------
    gprn_pkg::result_t o_res_reg;
    logic              o_vld_reg;

    always_ff @(posedge aclk) begin
        if (a_emit && a_fire) begin
            o_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            touch_reg <= '0;
        end else begin
            if (s_fire) begin
                a_vld_reg <= 1'b1;
            end else if (a_fire) begin
                a_vld_reg <= 1'b0;
            end
            o_vld_reg <= (a_emit && a_fire) || (o_vld_reg && !m_tready);
            // touch tracking moves only with a result
            if (a_emit && a_fire) begin
                touch_reg <= touch_next;
            end
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {3'd0, o_res_reg.touch_delta_x, o_res_reg.right_trigger,
                       o_res_reg.left_trigger, o_res_reg.right_y, o_res_reg.right_x,
                       o_res_reg.left_y, o_res_reg.left_x, o_res_reg.buttons,
                       o_res_reg.out_instance, o_res_reg.out_slot};

    // ---------------- assertions ----------------
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_vld_reg |-> s_tready)
        else $error("input stage empty but request refused");

    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_emit && a_fire) |=> o_vld_reg)
        else $error("emitted request lost before result register");

    a_drop_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_fire && !a_emit && !(o_vld_reg && !m_tready)) |=> !o_vld_reg)
        else $error("dropped request produced a result");

    a_lift_clears_drag: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_emit && a_fire && a_rep_reg.finger_lifted) |=> !touch_reg.dragging)
        else $error("finger lift did not clear dragging");

endmodule

// File: sim/gamepad_report_normalizer_unit_tb.sv
// Self-checking testbench for gamepad_report_normalizer_unit: stream requests in, results out.
// Depends on gprn_pkg and the unit RTL only; the expected results come from a predictor here.
module gamepad_report_normalizer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 8;
    localparam int SETTLE_CYC  = 8;       // keep some margin
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYC    = 300;     // long receiver hold-off

    logic                             aclk    = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [gprn_pkg::TDATA_IN_W-1:0]  s_tdata  = '0;
    logic [7:0]                       s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [gprn_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                             psel    = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite  = 1'b0;
    logic [3:0]                       paddr   = '0;
    logic [31:0]                      pwdata  = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    gamepad_report_normalizer_unit #(.DEVICE_SLOTS(SLOTS)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: kept report per slot, shared touch tracking, regs
    // ------------------------------------------------------------------
    logic [7:0]  kept_analog  [SLOTS][6] = '{default: '0}; // lx, ly, rx, ry, tl, tr
    logic [17:0] kept_buttons [SLOTS]    = '{default: '0};
    logic [23:0] kept_touch   [SLOTS]    = '{default: '0};
    logic [11:0] drag_last_x  = '0;
    logic        drag_active  = 1'b0;

    logic [7:0]  cfg_deadzone  = gprn_pkg::DEADZONE_RST;
    logic [7:0]  cfg_threshold = gprn_pkg::THRESHOLD_RST;
    logic [6:0]  cfg_delta_lim = gprn_pkg::DELTA_LIMIT_RST;

    gprn_pkg::result_t pending_results [$];
    int      err_cnt = 0;
    int      cycle_cnt = 0;

    // idling controls, read by the sender task and the receiver process
    bit tx_idle_en   = 1'b1;
    bit rx_idle_en   = 1'b1;
    int rx_gap       = 0;
    int rx_hold_left = 0;

    // Stick conditioning: lift zero to 1, snap the open deadzone window to centre.
    function automatic logic [7:0] condition_axis(input logic [7:0] v);
        int unsigned w, h;
        w = v;
        h = cfg_deadzone / 2;
        if (w == 0) w = 1;
        if (w + h > gprn_pkg::STICK_CENTRE && w < gprn_pkg::STICK_CENTRE + h)
            w = gprn_pkg::STICK_CENTRE;
        return w[7:0];
    endfunction

    // Works out the result of one accepted request and updates the kept state.
    // Returns 0 where the request yields nothing.
    function automatic bit normalise_report(input gprn_pkg::report_t r,
                                            output gprn_pkg::result_t res);
        logic [7:0]  an [6];
        logic [2:0]  s;
        logic [3:0]  hat;
        logic [17:0] b;
        logic [11:0] x;
        bit          changed;
        int unsigned d;
        int          dx, lim, i;
        res = '0;
        if (r.rpt_id != gprn_pkg::REPORT_ID_GAMEPAD) return 1'b0;
        s  = r.device_slot;
        an = '{r.stick_lx, r.stick_ly, r.stick_rx, r.stick_ry, r.trigger_l, r.trigger_r};
        changed = (r.buttons_raw != kept_buttons[s]) || (r.touch_pos != kept_touch[s]);
        for (i = 0; i < 6; i++) begin
            d = (an[i] > kept_analog[s][i]) ? an[i] - kept_analog[s][i]
                                            : kept_analog[s][i] - an[i];
            if (d > cfg_threshold) changed = 1'b1;
        end
        if (!changed) return 1'b0;

        hat  = r.buttons_raw[3:0];
        b    = '0;
        b[0] = (hat == gprn_pkg::HAT_N) || (hat == gprn_pkg::HAT_NE)
            || (hat == gprn_pkg::HAT_NW);
        b[1] = (hat >= gprn_pkg::HAT_SE) && (hat <= gprn_pkg::HAT_SW);
        b[2] = (hat >= gprn_pkg::HAT_SW) && (hat <= gprn_pkg::HAT_NW);
        b[3] = (hat >= gprn_pkg::HAT_NE) && (hat <= gprn_pkg::HAT_SE);
        b[4] = r.buttons_raw[5];   // cross
        b[5] = r.buttons_raw[6];   // circle
        b[6] = r.buttons_raw[4];   // square
        b[7] = r.buttons_raw[7];   // triangle
        b[17:8] = r.buttons_raw[17:8];

        dx = 0;
        x  = r.touch_pos[11:0];
        if (!r.finger_lifted) begin
            if (drag_active) begin
                lim = cfg_delta_lim;
                dx  = int'(x) - int'(drag_last_x);
                if (dx > lim)  dx = lim;
                if (dx < -lim) dx = -lim;
            end
            drag_last_x = x;
            drag_active = 1'b1;
        end else begin
            drag_active = 1'b0;
        end

        res.out_slot      = s;
        res.out_instance  = r.interface_instance;
        res.buttons       = b;
        res.left_x        = condition_axis(r.stick_lx);
        res.left_y        = condition_axis(~r.stick_ly);
        res.right_x       = condition_axis(r.stick_rx);
        res.right_y       = condition_axis(~r.stick_ry);
        res.left_trigger  = r.trigger_l;
        res.right_trigger = r.trigger_r;
        res.touch_delta_x = dx[7:0];

        for (i = 0; i < 6; i++) kept_analog[s][i] = an[i];
        kept_buttons[s] = r.buttons_raw;
        kept_touch[s]   = r.touch_pos;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic gprn_pkg::report_t mk_report(input logic [7:0] id,
                                          input logic [2:0] slot,
                                          input logic [7:0] inst, input logic [7:0] lx,
                                          input logic [7:0] ly, input logic [7:0] rx,
                                          input logic [7:0] ry, input logic [17:0] btn,
                                          input logic [7:0] tl, input logic [7:0] tr,
                                          input logic lifted, input logic [23:0] tpos);
        gprn_pkg::report_t r;
        r.rpt_id = id;       r.device_slot = slot; r.interface_instance = inst;
        r.stick_lx = lx;     r.stick_ly = ly;      r.stick_rx = rx;  r.stick_ry = ry;
        r.buttons_raw = btn; r.trigger_l = tl;     r.trigger_r = tr;
        r.finger_lifted = lifted;
        r.touch_pos = tpos;
        return r;
    endfunction

    // copy of what is kept for a slot, finger lifted so the last touch x is untouched
    function automatic gprn_pkg::report_t kept_report(input logic [2:0] s);
        return mk_report(gprn_pkg::REPORT_ID_GAMEPAD, s, 8'h00, kept_analog[s][0],
                         kept_analog[s][1], kept_analog[s][2], kept_analog[s][3],
                         kept_buttons[s], kept_analog[s][4], kept_analog[s][5], 1'b1,
                         kept_touch[s]);
    endfunction

    // axis value biased to the extremes, the deadzone edges and the centre
    function automatic logic [7:0] pick_axis();
        int h;
        h = cfg_deadzone / 2;
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 8'd0 : 8'd255;
            1:       return 8'(128 - h - 1 + $urandom_range(0, 2));
            2:       return 8'(128 + h - 1 + $urandom_range(0, 2));
            3:       return 8'(126 + $urandom_range(0, 4));
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed reports built on the slot's kept one; some repeats with
    // jitter around the threshold, a few raw noise requests.
    function automatic gprn_pkg::report_t random_report();
        gprn_pkg::report_t r;
        logic [127:0] noise;
        logic [7:0]  an [6];
        int          v, thr, i, k;
        r = kept_report(3'($urandom_range(0, SLOTS - 1)));
        r.interface_instance = 8'($urandom);
        r.finger_lifted = ($urandom_range(0, 3) == 0);
        an = '{r.stick_lx, r.stick_ly, r.stick_rx, r.stick_ry, r.trigger_l, r.trigger_r};
        k = $urandom_range(0, 19);
        if (k < 2) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            return noise[$bits(gprn_pkg::report_t)-1:0];
        end else if (k < 5) begin
            // near-repeat: analog moves straddle the threshold
            thr = cfg_threshold;
            for (i = 0; i < 6; i++) begin
                v = int'(an[i]) + int'($urandom_range(0, 2 * thr + 2)) - (thr + 1);
                if (v < 0)   v = 0;
                if (v > 255) v = 255;
                an[i] = v[7:0];
            end
        end else begin
            for (i = 0; i < 4; i++) begin
                if ($urandom_range(0, 1)) begin
                    an[i] = pick_axis();
                    if (i == 1 || i == 3) an[i] = ~an[i];   // Y axes are inverted
                end
            end
            for (i = 4; i < 6; i++) begin
                if ($urandom_range(0, 2) == 0) an[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                else if ($urandom_range(0, 1)) an[i] = 8'($urandom);
            end
            case ($urandom_range(0, 2))
                0: r.buttons_raw = 18'($urandom);
                1: r.buttons_raw ^= 18'(1) << $urandom_range(0, 17);
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0, 1, 2: r.touch_pos = {12'($urandom),
                                        12'(drag_last_x + $urandom_range(0, 60) - 30)};
                3:       r.touch_pos = 24'($urandom);
                default: ;
            endcase
        end
        {r.stick_lx, r.stick_ly, r.stick_rx, r.stick_ry, r.trigger_l, r.trigger_r} =
            {an[0], an[1], an[2], an[3], an[4], an[5]};
        return r;
    endfunction

    // Offer one request, wait for the handshake, then predict its result.
    task automatic offer_report(input gprn_pkg::report_t r);
        gprn_pkg::result_t res;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, r.touch_pos, r.finger_lifted, r.trigger_r, r.trigger_l,
                     r.buttons_raw, r.stick_ry, r.stick_rx, r.stick_ly, r.stick_lx,
                     r.interface_instance, r.device_slot};
        s_tuser  <= r.rpt_id;
        do @(posedge aclk); while (!s_tready);
        if (normalise_report(r, res)) pending_results.push_back(res);
    endtask

    // Stop offering, let every expected result come out, then let the pipe settle
    // (an ignored request may still be in flight).
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // APB write: setup then access; lands on the edge with pready high.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gprn_pkg::REG_DEADZONE:    cfg_deadzone  = val[7:0];
            gprn_pkg::REG_THRESHOLD:   cfg_threshold = val[7:0];
            gprn_pkg::REG_DELTA_LIMIT: cfg_delta_lim = val[6:0];
            default: ;
        endcase
        // bus idle before the next transfer
        @(posedge aclk);
    endtask

    task automatic set_config(input int dz, input int thr, input int lim);
        wait_idle();
        reg_write(gprn_pkg::REG_DEADZONE, 32'(dz));
        reg_write(gprn_pkg::REG_THRESHOLD, 32'(thr));
        reg_write(gprn_pkg::REG_DELTA_LIMIT, 32'(lim));
    endtask

    // random requests until n of them carried the gamepad report id
    task automatic send_random(input int n);
        gprn_pkg::report_t r;
        int      got_id;
        got_id = 0;
        while (got_id < n) begin
            r = random_report();
            offer_report(r);
            if (r.rpt_id == gprn_pkg::REPORT_ID_GAMEPAD) got_id++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // all-zero report matches the cleared store; foreign report ids are dropped
    task automatic test_ignored_and_unchanged();
        offer_report(mk_report(gprn_pkg::REPORT_ID_GAMEPAD, 3'd0, 8'h00, 8'd0, 8'd0, 8'd0,
                               8'd0, 18'd0, 8'd0, 8'd0, 1'b0, 24'd0));
        offer_report(mk_report(8'd0, 3'd1, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255,
                               18'h3FFFF, 8'd255, 8'd255, 1'b0, 24'hFFFFFF));
        offer_report(mk_report(8'd2, 3'd2, 8'h5A, 8'd10, 8'd20, 8'd30, 8'd40,
                               18'h00F0F, 8'd1, 8'd2, 1'b1, 24'h123456));
        offer_report(mk_report(8'hFF, 3'd7, 8'h01, 8'd0, 8'd255, 8'd0, 8'd255,
                               18'h2AAAA, 8'd0, 8'd0, 1'b0, 24'h000FFF));
    endtask

    // every hat direction plus neutral codes 8 and 15, walking face/shoulder buttons, stick edges
    task automatic test_hat_and_buttons();
        logic [7:0]  stick [10];
        logic [3:0]  hat_code [10];
        logic [13:0] hi;
        int          i;
        stick    = '{8'd0, 8'd1, 8'd107, 8'd108, 8'd109, 8'd127, 8'd128, 8'd147, 8'd148,
                     8'd255};
        hat_code = '{gprn_pkg::HAT_N, gprn_pkg::HAT_NE, gprn_pkg::HAT_E, gprn_pkg::HAT_SE,
                     gprn_pkg::HAT_S, gprn_pkg::HAT_SW, gprn_pkg::HAT_W, gprn_pkg::HAT_NW,
                     4'd8, 4'd15};
        for (i = 0; i < 10; i++) begin
            hi = (i == 9) ? 14'h3FFF : 14'(1) << i;
            if (i == 8) hi = 14'h3C00;     // home, pad, l3, r3
            offer_report(mk_report(gprn_pkg::REPORT_ID_GAMEPAD, 3'(i),
                                   (i == 9) ? 8'd255 : 8'(i * 25),
                                   stick[i], stick[9 - i], stick[(i + 3) % 10],
                                   stick[(i + 6) % 10], {hi, hat_code[i]},
                                   8'(i * 28), 8'(255 - i * 28), 1'b1, 24'(i + 1)));
        end
    endtask

    // drag start, clamp both ways, small move, lift, restart, exact limit
    task automatic test_touch_tracking();
        logic [11:0] xs [8];
        logic        up [8];
        int          i;
        xs = '{12'd100, 12'd4095, 12'd4090, 12'd0, 12'd5, 12'd50, 12'd62, 12'd49};
        up = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
        for (i = 0; i < 8; i++) begin
            offer_report(mk_report(gprn_pkg::REPORT_ID_GAMEPAD, 3'd4, 8'h44, 8'd128, 8'd128,
                                   8'd128, 8'd128, 18'h00008, 8'd0, 8'd0, up[i],
                                   {(i == 1) ? 12'hFFF : 12'hABC, xs[i]}));
        end
    endtask

    // analog move equal to the threshold is no change, one more is
    task automatic test_change_threshold();
        gprn_pkg::report_t r;
        int      step;
        for (step = 2; step <= 3; step++) begin
            r = kept_report(3'd3);
            r.stick_lx = (r.stick_lx >= 8'd128) ? r.stick_lx - 8'(step)
                                                : r.stick_lx + 8'(step);
            offer_report(r);
        end
    endtask

    // several register settings, extremes included, each with random traffic
    task automatic test_config_sweep();
        int sets [6][3];
        int i;
        sets = '{'{0, 0, 0}, '{255, 255, 127}, '{254, 1, 1}, '{1, 0, 127},
                 '{-1, -1, -1}, '{40, 2, 12}};
        for (i = 0; i < 6; i++) begin
            if (sets[i][0] < 0)
                set_config($urandom_range(0, 255), $urandom_range(0, 8), $urandom_range(0, 127));
            else
                set_config(sets[i][0], sets[i][1], sets[i][2]);
            send_random(40);
        end
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        wait_idle();
        tx_idle_en   = 1'b0;
        rx_hold_left = HOLD_CYC;
        send_random(40);
        wait_idle();
        tx_idle_en = 1'b1;
    endtask

    // bulk traffic; the tail runs with no idling on either side
    task automatic test_random_stream();
        send_random(100);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random(50);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready bursts, plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_left != 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap != 0) begin
            m_tready <= 1'b0;
            rx_gap--;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic cmp_field(input string nm, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
            err_cnt++;
        end
    endtask

    // Result checker: each handshake against the oldest expectation, field by field.
    always @(posedge aclk) begin : check_result
        gprn_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("out_slot",      want.out_slot,      m_tdata[2:0]);
                cmp_field("out_instance",  want.out_instance,  m_tdata[10:3]);
                cmp_field("buttons",       want.buttons,       m_tdata[28:11]);
                cmp_field("left_x",        want.left_x,        m_tdata[36:29]);
                cmp_field("left_y",        want.left_y,        m_tdata[44:37]);
                cmp_field("right_x",       want.right_x,       m_tdata[52:45]);
                cmp_field("right_y",       want.right_y,       m_tdata[60:53]);
                cmp_field("left_trigger",  want.left_trigger,  m_tdata[68:61]);
                cmp_field("right_trigger", want.right_trigger, m_tdata[76:69]);
                cmp_field("touch_delta_x", want.touch_delta_x, m_tdata[84:77]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("gamepad_report_normalizer_unit_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_ignored_and_unchanged();
        test_hat_and_buttons();
        test_touch_tracking();
        test_change_threshold();
        test_config_sweep();
        test_backpressure();
        test_random_stream();

        wait_idle();
        if (err_cnt == 0) begin
            $display("gamepad_report_normalizer_unit_tb: done, clean");
        end else begin
            $display("gamepad_report_normalizer_unit_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/gprn_pkg.sv
rtl/gprn_store.sv
rtl/gprn_cond.sv
rtl/gamepad_report_normalizer_unit.sv
sim/gamepad_report_normalizer_unit_tb.sv
